### sv/tgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared types, constants and saturating helpers for the trilateration solver.
// ----------------------------------------------------------------------------
package tgs_pkg;

    localparam int MAX_DIM    = 4;
    localparam int NUM_COORDS = 4;
    localparam int CNT_W      = $clog2(MAX_DIM + 2);
    localparam int ROW_W      = $clog2(MAX_DIM);
    localparam int PROW_W     = $clog2(MAX_DIM + 1);
    localparam int COL_W      = $clog2(NUM_COORDS);

    localparam logic [CNT_W-1:0] RHS_COL = CNT_W'(MAX_DIM);
    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQR,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
        logic sh32;
    } t_arith_req;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL,
        AS_MUL_FIN,
        AS_DIV,
        AS_DIV_FIN
    } t_arith_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_B_SQ0,
        S_B_W0,
        S_B_SQ1,
        S_B_W1,
        S_B_R0,
        S_B_W2,
        S_B_R1,
        S_B_W3,
        S_E_PIV0,
        S_E_PIV,
        S_E_SW0,
        S_E_SW1,
        S_E_SW2,
        S_E_CHK,
        S_E_ROW,
        S_E_DIV,
        S_E_DIVW,
        S_E_UPD,
        S_E_UPW,
        S_X_INIT,
        S_X_MUL,
        S_X_MW,
        S_X_DIV,
        S_X_DW,
        S_OUT
    } t_state;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg,
                                                   input logic over);
        logic sat;
        sat = over || (m > 64'(SAT_MAX));
        if (sat) begin
            sat_mag = neg ? -SAT_MAX : SAT_MAX;
        end else begin
            sat_mag = neg ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d > $signed({SAT_MAX[63], SAT_MAX})) begin
            sat_sub64 = SAT_MAX;
        end else if (d < -$signed({SAT_MAX[63], SAT_MAX})) begin
            sat_sub64 = -SAT_MAX;
        end else begin
            sat_sub64 = d[63:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

### sv/trilateration_gauss_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trilateration_gauss_solver
// Sequence: an anchor that does not complete a set is only stored. The last
//   anchor starts build, elimination and back substitution, using the shared
//   multiply/divide unit (128-step divider) for each division, multiply or
//   square, then emits one result per cycle while the output is not stalled.
// Throughput: one set per solve; input is stalled while solving.
// Reset: synchronous, active low; dims_in_use returns to 3, anchor count to 0.
// ----------------------------------------------------------------------------
module trilateration_gauss_solver (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_coord_0,
    input  wire logic signed [31:0] i_coord_1,
    input  wire logic signed [31:0] i_coord_2,
    input  wire logic signed [31:0] i_coord_3,
    input  wire logic [30:0]        i_range_to_anchor,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_position_value,
    output logic [1:0]              o_axis_index,
    output logic                    o_final_component,
    output logic                    o_singular_flag,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_dims_in_use
);

    localparam int CW = tgs_pkg::CNT_W;
    localparam int RW = tgs_pkg::ROW_W;

    tgs_pkg::t_state          r_state, n_state;
    logic [2:0]               r_dims;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [CW-1:0]            r_i, n_i;
    logic [CW-1:0]            r_j, n_j;
    logic [CW-1:0]            r_k, n_k;
    logic [RW-1:0]            r_best, n_best;
    logic [63:0]              r_bmag, n_bmag;
    logic signed [63:0]       r_tmp, n_tmp;
    logic signed [63:0]       r_f, n_f;
    logic signed [63:0]       r_acc, n_acc;
    logic                     r_sing, n_sing;
    logic                     r_out_valid, n_out_valid;
    logic signed [31:0]       r_out_value, n_out_value;
    logic [1:0]               r_out_axis, n_out_axis;
    logic                     r_out_final, n_out_final;
    logic                     r_out_sing, n_out_sing;

    logic signed [63:0] r_mat [tgs_pkg::MAX_DIM][tgs_pkg::MAX_DIM + 1];
    logic signed [63:0] r_x   [tgs_pkg::MAX_DIM];
    logic signed [31:0] r_pst [tgs_pkg::MAX_DIM + 1][tgs_pkg::NUM_COORDS];
    logic [30:0]        r_rng [tgs_pkg::MAX_DIM + 1];

    logic [CW-1:0]                n_eff;
    logic [CW-1:0]                slot;
    logic                         in_acc, cfg_acc, out_take;
    logic [RW-1:0]                m_rrow, m_wrow;
    logic [CW-1:0]                m_rcol, m_wcol;
    logic                         m_we;
    logic signed [63:0]           m_wdata, m_rd;
    logic [tgs_pkg::PROW_W-1:0]   p_rrow, rg_row;
    logic [tgs_pkg::COL_W-1:0]    p_rcol;
    logic signed [63:0]           p_rd;
    logic [63:0]                  rg_rd;
    logic [RW-1:0]                x_idx, x_widx;
    logic                         x_we;
    logic signed [63:0]           x_rd;
    logic signed [63:0]           diff;
    tgs_pkg::t_arith_req          u_req;
    logic signed [63:0]           u_opa, u_opb, u_res;
    logic                         u_done;

    tgs_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (u_req),
        .i_opa    (u_opa),
        .i_opb    (u_opb),
        .o_done   (u_done),
        .o_result (u_res)
    );

    // a pending register write takes precedence over an anchor request
    assign o_in_stall  = (r_state != tgs_pkg::S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == tgs_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_take    = r_out_valid && !i_out_stall;

    always_comb begin
        if (r_dims == 3'd0) begin
            n_eff = CW'(1);
        end else if (CW'(r_dims) > CW'(tgs_pkg::MAX_DIM)) begin
            n_eff = CW'(tgs_pkg::MAX_DIM);
        end else begin
            n_eff = CW'(r_dims);
        end
        slot = (r_cnt > n_eff) ? n_eff : r_cnt;
    end

    assign m_rd  = r_mat[m_rrow][m_rcol];
    assign p_rd  = {{32{r_pst[p_rrow][p_rcol][31]}}, r_pst[p_rrow][p_rcol]};
    assign rg_rd = {33'd0, r_rng[rg_row]};
    assign x_rd  = r_x[x_idx];
    assign diff  = p_rd - r_tmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tgs_pkg::S_IDLE;
            r_dims      <= 3'd3;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_acc) begin
                r_dims <= i_cfg_dims_in_use;
                r_cnt  <= '0;
            end else begin
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_best      <= n_best;
        r_bmag      <= n_bmag;
        r_tmp       <= n_tmp;
        r_f         <= n_f;
        r_acc       <= n_acc;
        r_sing      <= n_sing;
        r_out_value <= n_out_value;
        r_out_axis  <= n_out_axis;
        r_out_final <= n_out_final;
        r_out_sing  <= n_out_sing;
        if (m_we) begin
            r_mat[m_wrow][m_wcol] <= m_wdata;
        end
        if (x_we) begin
            r_x[x_widx] <= u_res;
        end
        if (in_acc) begin
            r_pst[slot[tgs_pkg::PROW_W-1:0]][0] <= i_coord_0;
            r_pst[slot[tgs_pkg::PROW_W-1:0]][1] <= i_coord_1;
            r_pst[slot[tgs_pkg::PROW_W-1:0]][2] <= i_coord_2;
            r_pst[slot[tgs_pkg::PROW_W-1:0]][3] <= i_coord_3;
            r_rng[slot[tgs_pkg::PROW_W-1:0]]    <= i_range_to_anchor;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_best      = r_best;
        n_bmag      = r_bmag;
        n_tmp       = r_tmp;
        n_f         = r_f;
        n_acc       = r_acc;
        n_sing      = r_sing;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        n_out_value = r_out_value;
        n_out_axis  = r_out_axis;
        n_out_final = r_out_final;
        n_out_sing  = r_out_sing;

        u_req   = '{start: 1'b0, op: tgs_pkg::OP_MUL, sh32: 1'b0};
        u_opa   = '0;
        u_opb   = '0;
        m_rrow  = r_i[RW-1:0];
        m_rcol  = r_j;
        m_we    = 1'b0;
        m_wrow  = r_i[RW-1:0];
        m_wcol  = r_j;
        m_wdata = '0;
        p_rrow  = '0;
        p_rcol  = r_j[tgs_pkg::COL_W-1:0];
        rg_row  = '0;
        x_idx   = r_j[RW-1:0];
        x_we    = 1'b0;
        x_widx  = r_i[RW-1:0];

        unique case (r_state)
            tgs_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (slot < n_eff) begin
                        n_cnt = slot + CW'(1);
                    end else begin
                        n_cnt   = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_acc   = '0;
                        n_sing  = 1'b0;
                        n_state = tgs_pkg::S_B_SQ0;
                    end
                end
            end
            tgs_pkg::S_B_SQ0: begin
                u_req   = '{start: 1'b1, op: tgs_pkg::OP_SQR, sh32: 1'b0};
                u_opa   = p_rd;
                u_opb   = p_rd;
                n_tmp   = p_rd;
                n_state = tgs_pkg::S_B_W0;
            end
            tgs_pkg::S_B_W0: begin
                if (u_done) begin
                    n_acc   = r_acc - u_res;
                    n_state = tgs_pkg::S_B_SQ1;
                end
            end
            tgs_pkg::S_B_SQ1: begin
                p_rrow  = r_i[tgs_pkg::PROW_W-1:0] + tgs_pkg::PROW_W'(1);
                u_req   = '{start: 1'b1, op: tgs_pkg::OP_SQR, sh32: 1'b0};
                u_opa   = p_rd;
                u_opb   = p_rd;
                m_we    = 1'b1;
                m_wdata = {diff[62:0], 1'b0};
                n_state = tgs_pkg::S_B_W1;
            end
            tgs_pkg::S_B_W1: begin
                if (u_done) begin
                    n_acc = r_acc + u_res;
                    if (r_j + CW'(1) == n_eff) begin
                        n_j     = '0;
                        n_state = tgs_pkg::S_B_R0;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = tgs_pkg::S_B_SQ0;
                    end
                end
            end
            tgs_pkg::S_B_R0: begin
                u_req   = '{start: 1'b1, op: tgs_pkg::OP_SQR, sh32: 1'b0};
                u_opa   = rg_rd;
                u_opb   = rg_rd;
                n_state = tgs_pkg::S_B_W2;
            end
            tgs_pkg::S_B_W2: begin
                if (u_done) begin
                    n_acc   = r_acc + u_res;
                    n_state = tgs_pkg::S_B_R1;
                end
            end
            tgs_pkg::S_B_R1: begin
                rg_row  = r_i[tgs_pkg::PROW_W-1:0] + tgs_pkg::PROW_W'(1);
                u_req   = '{start: 1'b1, op: tgs_pkg::OP_SQR, sh32: 1'b0};
                u_opa   = rg_rd;
                u_opb   = rg_rd;
                n_state = tgs_pkg::S_B_W3;
            end
            tgs_pkg::S_B_W3: begin
                if (u_done) begin
                    m_we    = 1'b1;
                    m_wcol  = tgs_pkg::RHS_COL;
                    m_wdata = r_acc - u_res;
                    n_acc   = '0;
                    n_j     = '0;
                    if (r_i + CW'(1) == n_eff) begin
                        n_i     = '0;
                        n_state = tgs_pkg::S_E_PIV0;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = tgs_pkg::S_B_SQ0;
                    end
                end
            end
            tgs_pkg::S_E_PIV0: begin
                m_rcol  = r_i;
                n_bmag  = tgs_pkg::mag64(m_rd);
                n_best  = r_i[RW-1:0];
                n_j     = r_i + CW'(1);
                n_state = tgs_pkg::S_E_PIV;
            end
            tgs_pkg::S_E_PIV: begin
                m_rrow = r_j[RW-1:0];
                m_rcol = r_i;
                if (r_j < n_eff) begin
                    // first row with the largest magnitude wins
                    if (tgs_pkg::mag64(m_rd) > r_bmag) begin
                        n_bmag = tgs_pkg::mag64(m_rd);
                        n_best = r_j[RW-1:0];
                    end
                    n_j = r_j + CW'(1);
                end else begin
                    n_k     = '0;
                    n_state = (r_best != r_i[RW-1:0]) ? tgs_pkg::S_E_SW0 : tgs_pkg::S_E_CHK;
                end
            end
            tgs_pkg::S_E_SW0: begin
                m_rcol  = r_k;
                n_tmp   = m_rd;
                n_state = tgs_pkg::S_E_SW1;
            end
            tgs_pkg::S_E_SW1: begin
                m_rrow  = r_best;
                m_rcol  = r_k;
                m_we    = 1'b1;
                m_wcol  = r_k;
                m_wdata = m_rd;
                n_state = tgs_pkg::S_E_SW2;
            end
            tgs_pkg::S_E_SW2: begin
                m_we    = 1'b1;
                m_wrow  = r_best;
                m_wcol  = r_k;
                m_wdata = r_tmp;
                if (r_k == tgs_pkg::RHS_COL) begin
                    n_state = tgs_pkg::S_E_CHK;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = tgs_pkg::S_E_SW0;
                end
            end
            tgs_pkg::S_E_CHK: begin
                if (r_bmag == 64'd0) begin
                    n_sing  = 1'b1;
                    n_k     = '0;
                    n_state = tgs_pkg::S_OUT;
                end else begin
                    n_j     = r_i + CW'(1);
                    n_state = tgs_pkg::S_E_ROW;
                end
            end
            tgs_pkg::S_E_ROW: begin
                m_rrow = r_j[RW-1:0];
                m_rcol = r_i;
                if (r_j < n_eff) begin
                    n_tmp   = m_rd;
                    n_state = tgs_pkg::S_E_DIV;
                end else if (r_i + CW'(1) == n_eff) begin
                    n_state = tgs_pkg::S_X_INIT;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = tgs_pkg::S_E_PIV0;
                end
            end
            tgs_pkg::S_E_DIV: begin
                m_rcol  = r_i;
                u_req   = '{start: 1'b1, op: tgs_pkg::OP_DIV, sh32: 1'b1};
                u_opa   = r_tmp;
                u_opb   = m_rd;
                n_state = tgs_pkg::S_E_DIVW;
            end
            tgs_pkg::S_E_DIVW: begin
                if (u_done) begin
                    n_f     = u_res;
                    n_k     = r_i + CW'(1);
                    n_state = tgs_pkg::S_E_UPD;
                end
            end
            tgs_pkg::S_E_UPD: begin
                m_rcol = r_k;
                if (r_k > tgs_pkg::RHS_COL) begin
                    n_j     = r_j + CW'(1);
                    n_state = tgs_pkg::S_E_ROW;
                end else begin
                    u_req   = '{start: 1'b1, op: tgs_pkg::OP_MUL, sh32: 1'b1};
                    u_opa   = r_f;
                    u_opb   = m_rd;
                    n_state = tgs_pkg::S_E_UPW;
                end
            end
            tgs_pkg::S_E_UPW: begin
                m_rrow = r_j[RW-1:0];
                m_rcol = r_k;
                if (u_done) begin
                    m_we    = 1'b1;
                    m_wrow  = r_j[RW-1:0];
                    m_wcol  = r_k;
                    m_wdata = tgs_pkg::sat_sub64(m_rd, u_res);
                    n_k     = (r_k + CW'(1) == n_eff) ? tgs_pkg::RHS_COL : r_k + CW'(1);
                    n_state = tgs_pkg::S_E_UPD;
                end
            end
            tgs_pkg::S_X_INIT: begin
                m_rcol  = tgs_pkg::RHS_COL;
                n_acc   = m_rd;
                n_j     = r_i + CW'(1);
                n_state = tgs_pkg::S_X_MUL;
            end
            tgs_pkg::S_X_MUL: begin
                if (r_j < n_eff) begin
                    u_req   = '{start: 1'b1, op: tgs_pkg::OP_MUL, sh32: 1'b0};
                    u_opa   = m_rd;
                    u_opb   = x_rd;
                    n_state = tgs_pkg::S_X_MW;
                end else begin
                    n_state = tgs_pkg::S_X_DIV;
                end
            end
            tgs_pkg::S_X_MW: begin
                if (u_done) begin
                    n_acc   = tgs_pkg::sat_sub64(r_acc, u_res);
                    n_j     = r_j + CW'(1);
                    n_state = tgs_pkg::S_X_MUL;
                end
            end
            tgs_pkg::S_X_DIV: begin
                m_rcol  = r_i;
                u_req   = '{start: 1'b1, op: tgs_pkg::OP_DIV, sh32: 1'b0};
                u_opa   = r_acc;
                u_opb   = m_rd;
                n_state = tgs_pkg::S_X_DW;
            end
            tgs_pkg::S_X_DW: begin
                if (u_done) begin
                    x_we = 1'b1;
                    if (r_i == '0) begin
                        n_k     = '0;
                        n_state = tgs_pkg::S_OUT;
                    end else begin
                        n_i     = r_i - CW'(1);
                        n_state = tgs_pkg::S_X_INIT;
                    end
                end
            end
            tgs_pkg::S_OUT: begin
                x_idx = r_k[RW-1:0];
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_sing ? 32'sd0 : tgs_pkg::sat32(x_rd);
                    n_out_axis  = r_k[1:0];
                    n_out_final = (r_k + CW'(1) == n_eff);
                    n_out_sing  = r_sing;
                    if (r_k + CW'(1) == n_eff) begin
                        n_state = tgs_pkg::S_IDLE;
                    end else begin
                        n_k = r_k + CW'(1);
                    end
                end
            end
            default: begin
                n_state = tgs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_position_value  = r_out_value;
    assign o_axis_index      = r_out_axis;
    assign o_final_component = r_out_final;
    assign o_singular_flag   = r_out_sing;

endmodule
`default_nettype wire

### sv/tgs_arith.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgs_arith
// Shared multiply / divide unit: 64x64 multiply (rounded except squares at
// 16-bit shift) from four 32x32 partial products; 128-step restoring divider.
// ----------------------------------------------------------------------------
module tgs_arith (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire tgs_pkg::t_arith_req     i_req,
    input  wire logic signed [63:0]      i_opa,
    input  wire logic signed [63:0]      i_opb,
    output logic                         o_done,
    output logic signed [63:0]           o_result
);

    tgs_pkg::t_arith_state r_state, n_state;
    tgs_pkg::t_op          r_op, n_op;
    logic                  r_sh32, n_sh32;
    logic                  r_neg, n_neg;
    logic [63:0]           r_ma, n_ma;
    logic [63:0]           r_mb, n_mb;
    logic [127:0]          r_acc, n_acc;
    logic [63:0]           r_pp, n_pp;
    logic [1:0]            r_pp_sh, n_pp_sh;
    logic [6:0]            r_cnt, n_cnt;
    logic [63:0]           r_rem, n_rem;
    logic                  r_done, n_done;
    logic signed [63:0]    r_res, n_res;

    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic [127:0] pp_wide;
    logic [64:0]  div_t, div_diff;
    logic         div_ge;
    logic [127:0] rnd, p_rnd, q_full;
    logic         up;
    logic [63:0]  lo_inc;
    logic [63:0]  opa_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgs_pkg::AS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_sh32  <= n_sh32;
        r_neg   <= n_neg;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_acc   <= n_acc;
        r_pp    <= n_pp;
        r_pp_sh <= n_pp_sh;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_res   <= n_res;
    end

    always_comb begin
        mul_a = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        mul_b = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        prod  = mul_a * mul_b;

        unique case (r_pp_sh)
            2'd0:    pp_wide = {64'd0, r_pp};
            2'd1:    pp_wide = {32'd0, r_pp, 32'd0};
            default: pp_wide = {r_pp, 64'd0};
        endcase

        div_t    = {r_rem, r_acc[127]};
        div_ge   = div_t >= {1'b0, r_mb};
        div_diff = div_t - {1'b0, r_mb};

        if (r_sh32) begin
            rnd = 128'd1 << 31;
        end else if (r_op == tgs_pkg::OP_SQR) begin
            rnd = 128'd0;
        end else begin
            rnd = 128'd1 << 15;
        end
        p_rnd  = r_acc + rnd;
        q_full = r_sh32 ? (p_rnd >> 32) : (p_rnd >> 16);

        up     = {r_rem, 1'b0} >= {1'b0, r_mb};
        lo_inc = r_acc[63:0] + {63'd0, up};

        opa_mag = tgs_pkg::mag64(i_opa);

        n_state = r_state;
        n_op    = r_op;
        n_sh32  = r_sh32;
        n_neg   = r_neg;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_acc   = r_acc;
        n_pp    = r_pp;
        n_pp_sh = r_pp_sh;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_res   = r_res;
        n_done  = 1'b0;

        unique case (r_state)
            tgs_pkg::AS_IDLE: begin
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_sh32 = i_req.sh32;
                    n_neg  = i_opa[63] ^ i_opb[63];
                    n_ma   = opa_mag;
                    n_mb   = tgs_pkg::mag64(i_opb);
                    n_cnt  = 7'd0;
                    n_rem  = 64'd0;
                    if (i_req.op == tgs_pkg::OP_DIV) begin
                        n_acc   = i_req.sh32 ? {32'd0, opa_mag, 32'd0}
                                             : {48'd0, opa_mag, 16'd0};
                        n_state = tgs_pkg::AS_DIV;
                    end else begin
                        n_acc   = 128'd0;
                        n_state = tgs_pkg::AS_MUL;
                    end
                end
            end
            tgs_pkg::AS_MUL: begin
                if (r_cnt != 7'd4) begin
                    n_pp    = prod;
                    n_pp_sh = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                end
                if (r_cnt != 7'd0) begin
                    n_acc = r_acc + pp_wide;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd4) begin
                    n_state = tgs_pkg::AS_MUL_FIN;
                end
            end
            tgs_pkg::AS_MUL_FIN: begin
                n_res   = tgs_pkg::sat_mag(q_full[63:0], r_neg, |q_full[127:64]);
                n_done  = 1'b1;
                n_state = tgs_pkg::AS_IDLE;
            end
            tgs_pkg::AS_DIV: begin
                n_rem = div_ge ? div_diff[63:0] : div_t[63:0];
                n_acc = {r_acc[126:0], div_ge};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    n_state = tgs_pkg::AS_DIV_FIN;
                end
            end
            tgs_pkg::AS_DIV_FIN: begin
                n_res   = tgs_pkg::sat_mag(lo_inc, r_neg,
                                           (|r_acc[127:64]) || (up && (&r_acc[63:0])));
                n_done  = 1'b1;
                n_state = tgs_pkg::AS_IDLE;
            end
            default: begin
                n_state = tgs_pkg::AS_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire
